>>> hw/rtl/pfdf_pkg.sv
// Shared operation codes, fixed constants and types for the page framebuffer flush block.
`timescale 1ns / 1ps

package pfdf_pkg;

   // Operation codes carried by the request.
   localparam logic [2:0] OP_PIXEL    = 3'd0;
   localparam logic [2:0] OP_CLEAR    = 3'd1;
   localparam logic [2:0] OP_SCAN     = 3'd2;
   localparam logic [2:0] OP_END      = 3'd3;
   localparam logic [2:0] OP_FULL_REQ = 3'd4;

   // Pixel rows per page; a byte holds one column of one page.
   localparam int PAGE_HEIGHT = 8;

   // Reset value of the panel column offset.
   localparam logic [1:0] COLUMN_OFFSET_RESET = 2'd2;

   // Write enables from the controller to the two stores.
   typedef struct packed {
      logic frame_we;
      logic shadow_we;
   } pfdf_wr_type;

endpackage

>>> hw/rtl/pfdf_store.sv
// Frame and shadow byte memories with one write port and one registered read port each.
`timescale 1ns / 1ps

module pfdf_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                  clock,
   input  logic [AW-1:0]         rd_addr,
   input  logic [AW-1:0]         wr_addr,
   input  pfdf_pkg::pfdf_wr_type wr_ctl,
   input  logic [7:0]            wr_frame_data,
   input  logic [7:0]            wr_shadow_data,
   output logic [7:0]            frame_q,
   output logic [7:0]            shadow_q
);
   import pfdf_pkg::*;

   logic [7:0] frame_mem  [DEPTH];
   logic [7:0] shadow_mem [DEPTH];

   // Frame store: read every cycle, written on request.
   always_ff @(posedge clock) begin
      if (wr_ctl.frame_we) begin
         frame_mem[wr_addr] <= wr_frame_data;
      end
      frame_q <= frame_mem[rd_addr];
   end

   // Shadow store: what the panel last received.
   always_ff @(posedge clock) begin
      if (wr_ctl.shadow_we) begin
         shadow_mem[wr_addr] <= wr_shadow_data;
      end
      shadow_q <= shadow_mem[rd_addr];
   end

endmodule

>>> hw/rtl/page_framebuffer_dirty_flush.sv
// Top level: request decode, read-modify-write sequencing, flags and store clearing.
// A taken scan is latched with its memory read, decided in the modify state and strobed
// on the rsp_ ports from the result registers. Busy covers the write-back cycle of the
// read-modify-write on the registered-read frame and shadow memories, so no new request
// is taken before the last is written back. Reset and a clear transaction sweep both
// memories one entry a cycle and hold busy to the sweep's end. The receiver cannot stall.
`timescale 1ns / 1ps

module page_framebuffer_dirty_flush #(
   parameter int WIDTH = 128,
   parameter int PAGES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_operation,
   input  logic [6:0] req_x,
   input  logic [5:0] req_y,
   input  logic       req_pixel_on,
   input  logic [2:0] req_page,
   input  logic [6:0] req_column,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   output logic       rsp_strobe,
   output logic [2:0] rsp_out_page,
   output logic [7:0] rsp_column_address,
   output logic [7:0] rsp_data,
   output logic       rsp_needs_address,
   output logic       rsp_row_last
);
   import pfdf_pkg::*;

   localparam int DEPTH = PAGES * WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [PAGES-1:0] dirty_ff, dirty_in;
   logic             full_ff, full_in;
   logic [1:0]       offset_ff;

   logic [2:0]       op_ff;
   logic             on_ff;
   logic [2:0]       bit_ff;
   logic [2:0]       page_ff;
   logic [6:0]       col_ff;
   logic [AW-1:0]    addr_ff;
   logic             ok_ff;

   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]       rsp_page_ff;
   logic [7:0]       rsp_col_ff;
   logic [7:0]       rsp_data_ff;
   logic             rsp_need_ff;
   logic             rsp_last_ff;
   logic             emit_need, emit_last;

   logic             accept;
   logic [2:0]       acc_page;
   logic [6:0]       acc_col;
   logic             acc_ok;
   logic [AW-1:0]    acc_addr;

   pfdf_wr_type      wr_ctl;
   logic [AW-1:0]    wr_addr;
   logic [7:0]       wr_frame_data, wr_shadow_data;
   logic [7:0]       frame_q, shadow_q;
   logic [7:0]       bit_mask;
   logic             page_dirty;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Decode page, column and range of the incoming transaction.
   always_comb begin
      if (req_operation == OP_PIXEL) begin
         acc_page = req_y[5:3];
         acc_col  = req_x;
      end else begin
         acc_page = req_page;
         acc_col  = req_column;
      end
      acc_ok   = ({1'b0, acc_page} < 4'(PAGES)) && ({2'b0, acc_col} < 9'(WIDTH));
      acc_addr = AW'(int'(acc_page) * WIDTH + int'(acc_col));
   end

   // Latch the transaction; the memory read is issued at the same edge.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         on_ff   <= req_pixel_on;
         bit_ff  <= req_y[2:0];
         page_ff <= acc_page;
         col_ff  <= acc_col;
         addr_ff <= acc_addr;
         ok_ff   <= acc_ok;
      end
   end

   // Next state, modify step and clear sweep: flags, store writes and the result.
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      dirty_in       = dirty_ff;
      full_in        = full_ff;
      rsp_strobe_in  = 1'b0;
      emit_need      = 1'b1;
      emit_last      = 1'b1;
      wr_ctl         = '0;
      wr_addr        = addr_ff;
      bit_mask       = 8'(1) << bit_ff;
      page_dirty     = dirty_ff[page_ff[PW-1:0]];
      wr_frame_data  = on_ff ? (frame_q | bit_mask) : (frame_q & ~bit_mask);
      wr_shadow_data = frame_q;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (op_ff)
               OP_PIXEL: begin
                  if (ok_ff) begin
                     wr_ctl.frame_we             = 1'b1;
                     dirty_in[page_ff[PW-1:0]] = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  dirty_in = '1;
                  full_in  = 1'b1;
                  clr_in   = '0;
                  state_in = ST_CLEAR;
               end
               OP_SCAN: begin
                  if (ok_ff && full_ff) begin
                     wr_ctl.shadow_we = 1'b1;
                     rsp_strobe_in    = 1'b1;
                     emit_need        = (col_ff == 7'd0);
                     emit_last        = ({1'b0, col_ff} == 8'(WIDTH - 1));
                  end else if (ok_ff && page_dirty && (shadow_q != frame_q)) begin
                     wr_ctl.shadow_we = 1'b1;
                     rsp_strobe_in    = 1'b1;
                  end
               end
               OP_END: begin
                  dirty_in = '0;
                  full_in  = 1'b0;
               end
               OP_FULL_REQ: begin
                  full_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_CLEAR: begin
            wr_ctl.frame_we  = 1'b1;
            wr_ctl.shadow_we = 1'b1;
            wr_addr          = clr_ff;
            wr_frame_data    = '0;
            wr_shadow_data   = '0;
            clr_in           = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state; reset starts with a clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         dirty_ff      <= '0;
         full_ff       <= 1'b1;
         offset_ff     <= COLUMN_OFFSET_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         dirty_ff      <= dirty_in;
         full_ff       <= full_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_page_ff <= page_ff;
         rsp_col_ff  <= {1'b0, col_ff} + {6'b0, offset_ff};
         rsp_data_ff <= frame_q;
         rsp_need_ff <= emit_need;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_out_page       = rsp_page_ff;
   assign rsp_column_address = rsp_col_ff;
   assign rsp_data           = rsp_data_ff;
   assign rsp_needs_address  = rsp_need_ff;
   assign rsp_row_last       = rsp_last_ff;

   // Frame and shadow memories.
   pfdf_store #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_store (
      .clock         (clock),
      .rd_addr       (acc_addr),
      .wr_addr       (wr_addr),
      .wr_ctl        (wr_ctl),
      .wr_frame_data (wr_frame_data),
      .wr_shadow_data(wr_shadow_data),
      .frame_q       (frame_q),
      .shadow_q      (shadow_q)
   );

`ifndef SYNTHESIS
   // A result only follows a modify cycle.
   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_EXEC))
      else $error("result strobe without a preceding modify cycle");

   // An accepted transaction always moves to the modify cycle.
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_EXEC))
      else $error("accepted transaction did not enter the modify cycle");

   // Outside full mode every emitted byte carries its own address and ends its transaction.
   a_partial_framing: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !$past(full_ff)) |-> (rsp_needs_address && rsp_row_last))
      else $error("partial update byte without address and end marks");

   // A clear sets every dirty bit and the full refresh flag.
   a_clear_flags: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && op_ff == OP_CLEAR) |=> (full_ff && (&dirty_ff)))
      else $error("clear did not mark all pages for refresh");
`endif

endmodule
